### design/scc_pkg.sv
// ----------------------------------------------------------------------------
// scc_pkg
// Shared types, defaults and register codes of the staged cooler controller.
// ----------------------------------------------------------------------------
package scc_pkg;

  // default build of the block
  localparam int COOLER_COUNT_DEF = 8;
  localparam int TIME_WIDTH_DEF   = 32;

  // configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_TEMP  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LEVEL_STEP = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HYSTERESIS = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ALARM_TEMP = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_ARM_TEMP   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_LIMIT = 3'd5;
  localparam logic [CFG_INDEX_W-1:0] REG_PURGE_SPAN = 3'd6;

  // register reset values
  localparam logic signed [11:0] BASE_TEMP_RST  = 12'sd288;
  localparam logic [7:0]         LEVEL_STEP_RST = 8'd4;
  localparam logic [7:0]         HYSTERESIS_RST = 8'd2;
  localparam logic signed [11:0] ALARM_TEMP_RST = 12'sd384;
  localparam logic signed [11:0] ARM_TEMP_RST   = 12'sd304;
  localparam logic [31:0]        IDLE_LIMIT_RST = 32'd300000;
  localparam logic [31:0]        PURGE_SPAN_RST = 32'd10000;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;      // capture the incoming word
    logic level_en;  // arm, alarm and level update
    logic scan_en;   // drive one cooler and weigh its idle time
    logic purge_en;  // start or end a purge
    logic out_load;  // move the finished result into the output register
  } scc_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;  // output register can take a result this cycle
  } scc_status_t;

endpackage

### design/scc_if.sv
// ----------------------------------------------------------------------------
// scc_if
// Tick and result channels of the staged cooler controller.
// ----------------------------------------------------------------------------
interface scc_tick_if;
  logic               valid;
  logic               ready;
  logic signed [11:0] temperature;
  logic [31:0]        time_ms;

  modport source (output valid, output temperature, output time_ms, input ready);
  modport sink   (input valid, input temperature, input time_ms, output ready);
endinterface

interface scc_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] cooler_on_mask;
  logic [3:0] cooling_level;
  logic       alarm_armed;
  logic       alarm_pin;
  logic       purge_active;
  logic [2:0] purge_index;

  modport source (output valid, output cooler_on_mask, output cooling_level,
                  output alarm_armed, output alarm_pin, output purge_active,
                  output purge_index, input ready);
  modport sink   (input valid, input cooler_on_mask, input cooling_level,
                  input alarm_armed, input alarm_pin, input purge_active,
                  input purge_index, output ready);
endinterface

### design/scc_datapath.sv
// ----------------------------------------------------------------------------
// scc_datapath
// Registers, level arithmetic, cooler drive, idle-time scan and purge logic.
// ----------------------------------------------------------------------------
module scc_datapath #(
  parameter int COOLER_COUNT = scc_pkg::COOLER_COUNT_DEF,
  parameter int TIME_WIDTH   = scc_pkg::TIME_WIDTH_DEF,
  localparam int IW = (COOLER_COUNT > 1) ? $clog2(COOLER_COUNT) : 1,
  localparam int SW = $clog2(COOLER_COUNT + 1)
) (
  input  logic                           clk,
  input  logic                           rst,
  // configuration writes
  input  logic                           cfg_we,
  input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data,
  // incoming word
  input  logic signed [11:0]             temperature,
  input  logic [31:0]                    time_ms,
  // control
  input  scc_pkg::scc_cmd_t              cmd,
  input  logic [IW-1:0]                  scan_idx,
  output scc_pkg::scc_status_t           status,
  // result register
  input  logic                           res_ready,
  output logic                           res_valid,
  output logic [7:0]                     cooler_on_mask,
  output logic [3:0]                     cooling_level,
  output logic                           alarm_armed,
  output logic                           alarm_pin,
  output logic                           purge_active,
  output logic [2:0]                     purge_index
);

  localparam int CW  = (TIME_WIDTH > 32) ? TIME_WIDTH : 32;
  localparam int LTW = SW + 10;
  localparam logic [SW-1:0] NO_PURGE = SW'(COOLER_COUNT);

  // configuration registers
  logic signed [11:0] base_temp;
  logic [7:0]         level_step;
  logic [7:0]         hysteresis;
  logic signed [11:0] alarm_temp;
  logic signed [11:0] arm_temp;
  logic [31:0]        idle_limit;
  logic [31:0]        purge_span;

  // block state
  logic [SW-1:0]           level;
  logic [SW-1:0]           purge_slot;
  logic                    armed;
  logic                    alarm_level;
  logic                    blink;
  logic [COOLER_COUNT-1:0] cooler;
  logic [TIME_WIDTH-1:0]   last_on [COOLER_COUNT];

  // per-tick working registers
  logic signed [11:0]    temp;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] best;
  logic [IW-1:0]         oldest;

  // combinational values
  logic [SW+7:0]         prod;
  logic signed [LTW-1:0] level_temp;
  logic signed [LTW-1:0] raise_temp;
  logic signed [LTW-1:0] temp_x;
  logic                  armed_next;
  logic [IW-1:0]         slot_idx;
  logic [IW-1:0]         rd_idx;
  logic [TIME_WIDTH-1:0] elapsed_raw;
  logic [TIME_WIDTH-1:0] elapsed;
  logic                  driven;
  logic                  level_on;

  // configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      base_temp  <= scc_pkg::BASE_TEMP_RST;
      level_step <= scc_pkg::LEVEL_STEP_RST;
      hysteresis <= scc_pkg::HYSTERESIS_RST;
      alarm_temp <= scc_pkg::ALARM_TEMP_RST;
      arm_temp   <= scc_pkg::ARM_TEMP_RST;
      idle_limit <= scc_pkg::IDLE_LIMIT_RST;
      purge_span <= scc_pkg::PURGE_SPAN_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        scc_pkg::REG_BASE_TEMP:  base_temp  <= signed'(cfg_data[11:0]);
        scc_pkg::REG_LEVEL_STEP: level_step <= cfg_data[7:0];
        scc_pkg::REG_HYSTERESIS: hysteresis <= cfg_data[7:0];
        scc_pkg::REG_ALARM_TEMP: alarm_temp <= signed'(cfg_data[11:0]);
        scc_pkg::REG_ARM_TEMP:   arm_temp   <= signed'(cfg_data[11:0]);
        scc_pkg::REG_IDLE_LIMIT: idle_limit <= cfg_data;
        scc_pkg::REG_PURGE_SPAN: purge_span <= cfg_data;
        default: ;
      endcase
    end
  end

  // level thresholds: base + level * step, then the raise margin
  always_comb begin
    prod       = (SW+8)'(level) * (SW+8)'(level_step);
    level_temp = LTW'(base_temp) + signed'({2'b00, prod});
    raise_temp = level_temp + LTW'(signed'({1'b0, hysteresis}));
    temp_x     = LTW'(temp);
    armed_next = armed || (temp < arm_temp);
  end

  // one read address: scan index, or the purged cooler during the purge step
  assign slot_idx    = purge_slot[IW-1:0];
  assign rd_idx      = cmd.purge_en ? slot_idx : scan_idx;
  assign elapsed_raw = now - last_on[rd_idx];
  assign driven      = SW'(scan_idx) != purge_slot;
  assign level_on    = SW'(scan_idx) < level;
  // a cooler stamped in this step has zero idle time
  assign elapsed     = (driven && level_on) ? '0 : elapsed_raw;

  // tick capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      temp <= temperature;
      now  <= TIME_WIDTH'(time_ms);
    end
  end

  // arm, alarm and staged level
  always_ff @(posedge clk) begin
    if (rst) begin
      level       <= '0;
      armed       <= 1'b0;
      alarm_level <= 1'b0;
      blink       <= 1'b0;
    end else if (cmd.level_en) begin
      armed <= armed_next;
      if (armed_next && (temp >= alarm_temp)) begin
        alarm_level <= blink;
      end
      blink <= ~blink;
      if (temp_x > raise_temp) begin
        if (level < NO_PURGE) begin
          level <= level + 1'b1;
        end
      end else if (temp_x < level_temp) begin
        if (level != '0) begin
          level <= level - 1'b1;
        end
      end
    end
  end

  // longest idle time seen in the scan, lowest index on a tie
  always_ff @(posedge clk) begin
    if (cmd.scan_en) begin
      if ((scan_idx == '0) || (elapsed > best)) begin
        best   <= elapsed;
        oldest <= scan_idx;
      end
    end
  end

  // cooler drive, stamps and purge rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      cooler     <= '0;
      purge_slot <= NO_PURGE;
      for (int i = 0; i < COOLER_COUNT; i++) begin
        last_on[i] <= '0;
      end
    end else if (cmd.scan_en) begin
      if (driven) begin
        cooler[scan_idx] <= level_on;
        if (level_on) begin
          last_on[scan_idx] <= now;
        end
      end
    end else if (cmd.purge_en) begin
      if (purge_slot == NO_PURGE) begin
        if (CW'(best) > CW'(idle_limit)) begin
          purge_slot      <= SW'(oldest);
          last_on[oldest] <= now;
          cooler[oldest]  <= 1'b1;
        end
      end else if (CW'(elapsed_raw) >= CW'(purge_span)) begin
        last_on[slot_idx] <= now;
        cooler[slot_idx]  <= 1'b0;
        purge_slot        <= NO_PURGE;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      cooler_on_mask <= 8'(cooler);
      cooling_level  <= 4'(level);
      alarm_armed    <= armed;
      alarm_pin      <= alarm_level;
      purge_active   <= purge_slot != NO_PURGE;
      purge_index    <= (purge_slot != NO_PURGE) ? 3'(purge_slot) : 3'd0;
    end
  end

  assign status.out_free = !res_valid || res_ready;

endmodule

### design/scc_ctrl.sv
// ----------------------------------------------------------------------------
// scc_ctrl
// Tick sequencer: capture, level update, cooler scan, purge, result hand-off.
// ----------------------------------------------------------------------------
module scc_ctrl #(
  parameter int COOLER_COUNT = scc_pkg::COOLER_COUNT_DEF,
  localparam int IW = (COOLER_COUNT > 1) ? $clog2(COOLER_COUNT) : 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 tick_valid,
  output logic                 tick_ready,
  input  scc_pkg::scc_status_t status,
  output scc_pkg::scc_cmd_t    cmd,
  output logic [IW-1:0]        scan_idx
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_LEVEL = 5'b00010,
    S_SCAN  = 5'b00100,
    S_PURGE = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

  localparam logic [IW-1:0] LAST_IDX = IW'(COOLER_COUNT - 1);

  state_t        state;
  state_t        state_next;
  logic [IW-1:0] scan_idx_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    scan_idx_next = scan_idx;
    cmd           = '0;
    tick_ready    = 1'b0;
    case (state)
      S_IDLE: begin
        tick_ready = 1'b1;
        if (tick_valid) begin
          cmd.load   = 1'b1;
          state_next = S_LEVEL;
        end
      end
      S_LEVEL: begin
        cmd.level_en  = 1'b1;
        scan_idx_next = '0;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (scan_idx == LAST_IDX) begin
          state_next = S_PURGE;
        end else begin
          scan_idx_next = scan_idx + 1'b1;
        end
      end
      S_PURGE: begin
        cmd.purge_en = 1'b1;
        state_next   = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      scan_idx <= '0;
    end else begin
      state    <= state_next;
      scan_idx <= scan_idx_next;
    end
  end

endmodule

### design/staged_cooler_controller_with_purge_unit.sv
// ----------------------------------------------------------------------------
// staged_cooler_controller_with_purge_unit
// Staged cooler controller with purge rotation and a blinking alarm.
// ----------------------------------------------------------------------------
// Each tick word (temperature in 1/16 degree, millisecond time) yields one
// result word. A tick occupies the sequencer through a capture step in which it
// is accepted, a level step, a scan step for each cooler while the sequencer
// walks the last-on stamps through a single read port, a purge step and a
// hand-off step. The result is loaded into the output register at the end of
// the hand-off step, and the next tick can be accepted in the cycle after that.
// A result still waiting in the output register holds the following tick at
// its hand-off step until the register frees. Configuration is written through
// cfg_we/cfg_index/cfg_data while no tick is in flight; no clearing pass is
// needed after reset.
module staged_cooler_controller_with_purge_unit #(
  parameter int COOLER_COUNT = scc_pkg::COOLER_COUNT_DEF,
  parameter int TIME_WIDTH   = scc_pkg::TIME_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data,
  scc_tick_if.sink                        tick,
  scc_result_if.source                    result
);

  localparam int IW = (COOLER_COUNT > 1) ? $clog2(COOLER_COUNT) : 1;

  scc_pkg::scc_cmd_t    cmd;
  scc_pkg::scc_status_t status;
  logic [IW-1:0]        scan_idx;

  // sequencer
  scc_ctrl #(
    .COOLER_COUNT (COOLER_COUNT)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .status     (status),
    .cmd        (cmd),
    .scan_idx   (scan_idx)
  );

  // datapath
  scc_datapath #(
    .COOLER_COUNT (COOLER_COUNT),
    .TIME_WIDTH   (TIME_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .temperature    (tick.temperature),
    .time_ms        (tick.time_ms),
    .cmd            (cmd),
    .scan_idx       (scan_idx),
    .status         (status),
    .res_ready      (result.ready),
    .res_valid      (result.valid),
    .cooler_on_mask (result.cooler_on_mask),
    .cooling_level  (result.cooling_level),
    .alarm_armed    (result.alarm_armed),
    .alarm_pin      (result.alarm_pin),
    .purge_active   (result.purge_active),
    .purge_index    (result.purge_index)
  );

endmodule

### design/scc_checker.sv
// ----------------------------------------------------------------------------
// scc_checker
// Port-level checks of the staged cooler controller, bound to the top level.
// ----------------------------------------------------------------------------
module scc_checker #(
  parameter int COOLER_COUNT = scc_pkg::COOLER_COUNT_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       tick_valid,
  input logic       tick_ready,
  input logic       res_valid,
  input logic       res_ready,
  input logic [7:0] cooler_on_mask,
  input logic [3:0] cooling_level,
  input logic       purge_active,
  input logic [2:0] purge_index
);

  // one tick in flight: no second word right after an accepted one
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    tick_valid && tick_ready |=> !tick_ready)
    else $error("tick accepted on consecutive cycles");

  // a stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(cooler_on_mask) &&
      $stable(cooling_level) && $stable(purge_index))
    else $error("stalled result changed");

  // idle purge reports index zero
  a_purge_index_idle: assert property (@(posedge clk) disable iff (rst)
    res_valid && !purge_active |-> purge_index == 3'd0)
    else $error("purge index set with no purge");

  // the purged cooler is running
  a_purge_cooler_on: assert property (@(posedge clk) disable iff (rst)
    res_valid && purge_active |-> (COOLER_COUNT > 8) || cooler_on_mask[purge_index])
    else $error("purged cooler is off");

  // level stays within the cooler count
  a_level_range: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> (COOLER_COUNT > 15) || (32'(cooling_level) <= COOLER_COUNT))
    else $error("cooling level above cooler count");

endmodule

bind staged_cooler_controller_with_purge_unit scc_checker #(
  .COOLER_COUNT (COOLER_COUNT)
) u_scc_checker (
  .clk            (clk),
  .rst            (rst),
  .tick_valid     (tick.valid),
  .tick_ready     (tick.ready),
  .res_valid      (result.valid),
  .res_ready      (result.ready),
  .cooler_on_mask (result.cooler_on_mask),
  .cooling_level  (result.cooling_level),
  .purge_active   (result.purge_active),
  .purge_index    (result.purge_index)
);

### sim/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the staged cooler controller with purge rotation.
// ----------------------------------------------------------------------------
// Tick words come from a backlog queue. A clocked driver presents them and a
// clocked monitor takes the result words. On every accepted tick a local copy
// of the controller (staged level, alarm latch, last-on stamps, purge slot)
// works out the status word that must come back. Each returned word is
// checked field by field against the oldest outstanding status. A short
// directed run at reset settings comes first. It is followed by phases of
// random ticks, each phase under a fresh set of register values, the extremes
// among them, with varying amounts of idling on both channels.
// ----------------------------------------------------------------------------
module tb;

  localparam int NCOOL       = scc_pkg::COOLER_COUNT_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int SETTLE_CYC  = 16;
  localparam int PHASES      = 10;
  localparam int PHASE_TICKS = 113;
  localparam int MAX_PRINTS  = 40;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
  typedef enum int {SET_LOW, SET_HIGH, SET_DEFAULT, SET_RANDOM} setting_kind_t;

  typedef struct {
    logic signed [11:0] temperature;
    logic [31:0]        time_ms;
  } tick_word_t;

  typedef struct packed {
    logic [7:0] cooler_on_mask;
    logic [3:0] cooling_level;
    logic       alarm_armed;
    logic       alarm_pin;
    logic       purge_active;
    logic [2:0] purge_index;
  } status_t;

  typedef struct {
    logic signed [11:0] base_temp;
    logic [7:0]         level_step;
    logic [7:0]         hysteresis;
    logic signed [11:0] alarm_temp;
    logic signed [11:0] arm_temp;
    logic [31:0]        idle_limit;
    logic [31:0]        purge_span;
  } settings_t;

  logic                            clk;
  logic                            rst;
  logic                            cfg_we;
  logic [scc_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [scc_pkg::CFG_DATA_W-1:0]  cfg_data;

  scc_tick_if   tick_ch ();
  scc_result_if res_ch ();

  staged_cooler_controller_with_purge_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .tick      (tick_ch),
    .result    (res_ch)
  );

  // words waiting to be sent, and status words still owed by the block
  tick_word_t  tick_backlog [$];
  status_t     due_status [$];
  tick_word_t  drv_word;
  status_t     mon_want;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int          mismatches;
  int          quiet_cycles;

  // local copy of the controller
  settings_t        m_cfg;
  int               m_level;
  logic [31:0]      m_stamp [NCOOL];
  logic [NCOOL-1:0] m_cool;
  int               m_purge;
  bit               m_armed;
  bit               m_alarm;
  bit               m_blink;

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // one controller tick: arm, alarm, level, cooler drive, purge
  function automatic status_t advance_controller(input logic signed [11:0] temp_in,
                                                 input logic [31:0] now);
    int          temp;
    int          lvl_temp;
    int          i;
    int          oldest;
    logic [31:0] best;
    logic [31:0] gap;
    status_t     st;
    temp = temp_in;
    if (!m_armed && temp < m_cfg.arm_temp) m_armed = 1'b1;
    // alarm latches the phase from before this tick's toggle
    if (m_armed && temp >= m_cfg.alarm_temp) m_alarm = m_blink;
    m_blink = !m_blink;

    // staged level, saturating at both ends
    lvl_temp = int'(m_cfg.base_temp) + m_level * int'(m_cfg.level_step);
    if (temp > lvl_temp + int'(m_cfg.hysteresis)) begin
      if (m_level < NCOOL) m_level++;
    end else if (temp < lvl_temp) begin
      if (m_level > 0) m_level--;
    end

    // level drive leaves the purged cooler alone
    for (i = 0; i < NCOOL; i++) begin
      if (i != m_purge) begin
        m_cool[i] = (i < m_level);
        if (i < m_level) m_stamp[i] = now;
      end
    end

    // purge: longest idle wins, ties to the lowest index
    if (m_purge >= NCOOL) begin
      oldest = 0;
      best   = now - m_stamp[0];
      for (i = 1; i < NCOOL; i++) begin
        gap = now - m_stamp[i];
        if (gap > best) begin
          best   = gap;
          oldest = i;
        end
      end
      if (best > m_cfg.idle_limit) begin
        m_purge         = oldest;
        m_stamp[oldest] = now;
        m_cool[oldest]  = 1'b1;
      end
    end else begin
      gap = now - m_stamp[m_purge];
      if (gap >= m_cfg.purge_span) begin
        m_stamp[m_purge] = now;
        m_cool[m_purge]  = 1'b0;
        m_purge          = NCOOL;
      end
    end

    st.cooler_on_mask = m_cool;
    st.cooling_level  = 4'(m_level);
    st.alarm_armed    = m_armed;
    st.alarm_pin      = m_alarm;
    st.purge_active   = (m_purge < NCOOL);
    st.purge_index    = st.purge_active ? 3'(m_purge) : 3'd0;
    return st;
  endfunction

  task automatic flag_mismatch(input string what);
    if (mismatches < MAX_PRINTS) $display("%0t: mismatch: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0h, want %0h", name, got, want));
  endtask

  task automatic write_reg(input logic [scc_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [scc_pkg::CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
  endtask

  task automatic set_idling(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      IDLE_SEND: begin send_idle_pct = 76; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 76; end
      default:   begin send_idle_pct = 22; recv_stall_pct = 22; end
    endcase
  endtask

  task automatic push_tick(input logic signed [11:0] temp, input logic [31:0] t_ms);
    tick_word_t w;
    w.temperature = temp;
    w.time_ms     = t_ms;
    tick_backlog.push_back(w);
  endtask

  // hold off until every word has been sent and every status has come back
  task automatic settle();
    while (tick_backlog.size() != 0 || tick_ch.valid || due_status.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // tick driver
  always @(posedge clk) begin
    if (rst) begin
      tick_ch.valid <= 1'b0;
    end else begin
      if (tick_ch.valid && tick_ch.ready)
        due_status.push_back(advance_controller(tick_ch.temperature, tick_ch.time_ms));
      if (!tick_ch.valid || tick_ch.ready) begin
        if (tick_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          drv_word = tick_backlog.pop_front();
          tick_ch.valid       <= 1'b1;
          tick_ch.temperature <= drv_word.temperature;
          tick_ch.time_ms     <= drv_word.time_ms;
        end else begin
          tick_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        if (due_status.size() == 0) begin
          flag_mismatch("status word with nothing outstanding");
        end else begin
          mon_want = due_status.pop_front();
          compare_field("cooler_on_mask", res_ch.cooler_on_mask, mon_want.cooler_on_mask);
          compare_field("cooling_level", res_ch.cooling_level, mon_want.cooling_level);
          compare_field("alarm_armed", res_ch.alarm_armed, mon_want.alarm_armed);
          compare_field("alarm_pin", res_ch.alarm_pin, mon_want.alarm_pin);
          compare_field("purge_active", res_ch.purge_active, mon_want.purge_active);
          compare_field("purge_index", res_ch.purge_index, mon_want.purge_index);
        end
      end
      res_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // watchdog on cycles with no word moving on either channel
  always @(posedge clk) begin
    if (rst || (tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int            k;
    int            ph;
    int            t;
    int            r;
    int unsigned   step_max;
    logic [31:0]   now_ms;
    settings_t     s;
    setting_kind_t kind;

    clk                 = 1'b0;
    rst                 = 1'b1;
    cfg_we              = 1'b0;
    cfg_index           = '0;
    cfg_data            = '0;
    tick_ch.valid       = 1'b0;
    tick_ch.temperature = '0;
    tick_ch.time_ms     = '0;
    res_ch.ready        = 1'b0;
    mismatches          = 0;
    quiet_cycles        = 0;
    now_ms              = '0;
    m_cfg = '{scc_pkg::BASE_TEMP_RST, scc_pkg::LEVEL_STEP_RST,
              scc_pkg::HYSTERESIS_RST, scc_pkg::ALARM_TEMP_RST,
              scc_pkg::ARM_TEMP_RST, scc_pkg::IDLE_LIMIT_RST,
              scc_pkg::PURGE_SPAN_RST};
    m_level = 0;
    m_cool  = '0;
    m_purge = NCOOL;
    m_armed = 1'b0;
    m_alarm = 1'b0;
    m_blink = 1'b0;
    for (k = 0; k < NCOOL; k++) m_stamp[k] = '0;
    set_idling(IDLE_NONE);

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed run at reset settings: hot while unarmed up to full level,
    // coldest down to level zero (arms), alarm threshold edges, then time
    // jumps that start and end purges, including a wrap of the clock
    for (k = 0; k < 9; k++) push_tick(12'h7FF, 32'(k * 500));
    for (k = 0; k < 8; k++) push_tick(12'h800, 32'(4500 + k * 500));
    push_tick(12'sd384, 32'd8500);
    push_tick(12'sd383, 32'd9000);
    push_tick(12'sd500, 32'd9500);
    push_tick(12'sd300, 32'd400000);
    push_tick(12'sd300, 32'd409999);
    push_tick(12'sd300, 32'd410000);
    push_tick(12'h800, 32'hFFFF_FFFF);
    push_tick(12'h7FF, 32'h0000_0010);
    now_ms = 32'h0000_0010;
    settle();

    // random phases, each under its own register settings
    for (ph = 1; ph <= PHASES; ph++) begin
      kind = (ph <= 3) ? setting_kind_t'(ph - 1) : SET_RANDOM;
      case (kind)
        SET_LOW: begin
          s = '{12'h800, 8'd0, 8'd0, 12'h800, 12'h800, 32'd0, 32'd0};
          step_max = 1000;
        end
        SET_HIGH: begin
          s = '{12'h7FF, 8'hFF, 8'hFF, 12'h7FF, 12'h7FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
          step_max = 32'h4000_0000;
        end
        SET_DEFAULT: begin
          s = '{scc_pkg::BASE_TEMP_RST, scc_pkg::LEVEL_STEP_RST,
                scc_pkg::HYSTERESIS_RST, scc_pkg::ALARM_TEMP_RST,
                scc_pkg::ARM_TEMP_RST, scc_pkg::IDLE_LIMIT_RST,
                scc_pkg::PURGE_SPAN_RST};
          step_max = 5000;
        end
        default: begin
          t = $urandom_range(0, 1200);
          s.base_temp  = 12'(t - 600);
          s.level_step = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 24));
          s.hysteresis = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 12));
          t = int'(s.base_temp) + int'($urandom_range(0, 80)) - 20;
          s.alarm_temp = 12'(t);
          s.arm_temp   = 12'($urandom);
          s.idle_limit = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 6000);
          s.purge_span = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4000);
          step_max = $urandom_range(1, 2500);
        end
      endcase

      // registers get junk above their width, which the block must drop
      write_reg(scc_pkg::REG_BASE_TEMP,  {20'($urandom), s.base_temp});
      write_reg(scc_pkg::REG_LEVEL_STEP, {24'($urandom), s.level_step});
      write_reg(scc_pkg::REG_HYSTERESIS, {24'($urandom), s.hysteresis});
      write_reg(scc_pkg::REG_ALARM_TEMP, {20'($urandom), s.alarm_temp});
      write_reg(scc_pkg::REG_ARM_TEMP,   {20'($urandom), s.arm_temp});
      write_reg(scc_pkg::REG_IDLE_LIMIT, s.idle_limit);
      write_reg(scc_pkg::REG_PURGE_SPAN, s.purge_span);
      @(posedge clk);
      cfg_we <= 1'b0;
      m_cfg = s;

      for (k = 0; k < PHASE_TICKS; k++) begin
        if (k % 40 == 0) set_idling(idle_mode_t'((ph + k / 40) % 4));
        // keep the backlog short so the level estimate stays current
        while (tick_backlog.size() >= 2) @(negedge clk);

        // mostly near the level and alarm thresholds, some anywhere
        r = $urandom_range(0, 99);
        if (r < 15) begin
          t = int'(12'sh000 ^ 12'($urandom));
          t = (t > 2047) ? t - 4096 : t;
        end else if (r < 35) begin
          t = int'(m_cfg.alarm_temp) + int'($urandom_range(0, 2)) - 1;
        end else begin
          t = int'(m_cfg.base_temp) + m_level * int'(m_cfg.level_step)
              + int'($urandom_range(0, int'(m_cfg.hysteresis) + 6)) - 3;
        end
        if (t > 2047) t = 2047;
        if (t < -2048) t = -2048;

        // time mostly creeps forward, sometimes jumps or wraps
        r = $urandom_range(0, 99);
        if (r < 80) now_ms = now_ms + $urandom_range(0, step_max);
        else if (r < 90) now_ms = now_ms + $urandom;
        else if (r < 95) now_ms = $urandom;

        push_tick(12'(t), now_ms);
      end
      settle();
    end

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
